### rtl/core/lldc_pkg.sv
package lldc_pkg;

  localparam int MAX_PILLARS = 16;
  localparam int IDX_W = $clog2(MAX_PILLARS);
  localparam int CNT_W = $clog2(MAX_PILLARS + 1);
  localparam int TIME_W = 24;
  localparam int DF_W = 32;
  localparam int RATE_W = 32;
  localparam int LOG_W = 40;
  localparam int EXP_TERMS = 24;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_REMOVE,
    CMD_DISCOUNT,
    CMD_FORWARD
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_ZERO_FACTOR,
    ST_NOT_INCREASING,
    ST_FULL,
    ST_LAST,
    ST_EMPTY,
    ST_BAD_INTERVAL,
    ST_ZERO_TIME
  } status_t;

  typedef enum logic [1:0] {
    K_EXACT,
    K_EXT,
    K_INT
  } kind_t;

  typedef enum logic [1:0] {
    DU_CURVE,
    DU_EXP,
    DU_FWD
  } div_use_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_NB_CAP,
    S_LOG_LD,
    S_LOG_NORM,
    S_LOG_SQ,
    S_LOG_ACC,
    S_LOG_DONE,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_ACC,
    S_DIV,
    S_CURVE_FIX,
    S_CURVE_DONE,
    S_EXP_Y,
    S_EXP_YCAP,
    S_EXP_MUL,
    S_EXP_DIVLD,
    S_EXP_TERM,
    S_EXP_FIN,
    S_FWD_CHK,
    S_FWD_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [TIME_W-1:0] time_a;
    logic [TIME_W-1:0] time_b;
    logic [DF_W-1:0]   discount_in;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [DF_W-1:0]          discount_out;
    logic signed [RATE_W-1:0] rate_out;
  } res_item_t;

endpackage

### rtl/core/log_linear_discount_curve_top.sv
// Log-linear discount curve: holds up to 16 pillars (Q8.16 time, Q2.30 factor) and answers
// discount and forward-rate queries, one command at a time. cmd_stall is high from the
// transfer of a command until its result is loaded into the output register; the output
// register lets the next command in while a result still waits. Append and remove finish
// at dispatch. A query walks the pillars one at a time, then runs everything through one
// shared 32x32 multiplier and one bit-per-cycle divider: each log2 normalizes the mantissa
// and then squares it once per fraction bit, each interpolation or rate takes a division,
// and the exp series takes a multiply and a division per term (up to 23 terms). A discount
// query ends at dispatch on an empty curve and skips log and exp on an exact pillar hit.
// A forward query ends at dispatch when the interval or the curve is rejected, and ends
// early when a zero pillar time stops it.
module log_linear_discount_curve_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  lldc_pkg::cmd_item_t  cmd_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output lldc_pkg::res_item_t  res_data
);

  localparam int IW = lldc_pkg::IDX_W;
  localparam int CW = lldc_pkg::CNT_W;
  localparam int TW = lldc_pkg::TIME_W;
  localparam int LW = lldc_pkg::LOG_W;

  lldc_pkg::state_t   state, state_next;
  lldc_pkg::kind_t    kind;
  lldc_pkg::div_use_t duse;

  logic [1:0]    op;
  logic [TW-1:0] ta, tb;
  logic [31:0]   dfi;
  logic [CW-1:0] count;

  logic [TW-1:0] tmem [lldc_pkg::MAX_PILLARS];
  logic [31:0]   fmem [lldc_pkg::MAX_PILLARS];
  logic [IW-1:0] rd_addr, last_addr;
  logic [TW-1:0] t_rd;
  logic [31:0]   f_rd;
  logic          mem_we;

  logic [CW-1:0] idx;
  logic [TW-1:0] qt;
  logic          pass;
  logic          second;
  logic [TW-1:0] hi_t;
  logic [31:0]   hi_f;
  logic [31:0]   fa, fb;
  logic [TW-1:0] mt, dv;

  logic [31:0]   lm;
  logic [4:0]    lp;
  logic [31:0]   lfrac;
  logic [4:0]    lrc;
  logic [32:0]   mm;
  logic [LW-1:0] lres, lsave, ldiff, nsrc, nabs, base;
  logic [LW-1:0] nmag;
  logic          nneg;

  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [63:0]   acc;

  logic [63:0]   dnum, dquo;
  logic [TW-1:0] dden, drem;
  logic [6:0]    dcnt;
  logic [TW:0]   trial;
  logic          dge;

  logic [63:0]   lval, la, base_x, fd, fmag;
  logic          fbig;
  logic          q_big;

  logic [31:0]   ey, eterm;
  logic [33:0]   esum;
  logic [4:0]    ek;
  logic signed [31:0] eip;
  logic          exp_sat, exp_zero;
  logic [5:0]    es;
  logic [34:0]   rnd, rsh;
  logic [33:0]   nat;

  logic [2:0]    r_status;
  logic [31:0]   r_dout, r_rout;

  logic          app_zero, app_noinc, app_full, app_ok;
  logic          empty, bad_iv;
  logic          res_free;

  // command checks
  assign app_zero  = (dfi == '0);
  assign app_noinc = (count != '0) && (ta <= t_rd);
  assign app_full  = (count >= CW'(lldc_pkg::MAX_PILLARS));
  assign app_ok    = !app_zero && !app_noinc && !app_full;
  assign empty     = (count == '0);
  assign bad_iv    = (tb <= ta);
  assign last_addr = IW'(count - CW'(1));

  // log2 datapath
  assign mm    = prod[63:31];
  assign lres  = {8'({3'b000, lp} - 8'd30), lfrac};
  assign ldiff = lsave - lres;
  assign nsrc  = (kind == lldc_pkg::K_INT) ? ldiff : lres;
  assign nabs  = nsrc[LW-1] ? (~nsrc + LW'(1)) : nsrc;

  // divider step
  assign trial = {drem, dnum[63]};
  assign dge   = (trial >= {1'b0, dden});

  // curve value and forward difference
  assign base_x = {{(64 - LW){base[LW-1]}}, base};
  assign fd     = la - lval;
  assign fmag   = fd[63] ? (~fd + 64'd1) : fd;
  assign fbig   = |fmag[63:54];
  assign q_big  = |dquo[63:32];

  // exp2 range and final rounding shift
  assign eip      = lval[63:32];
  assign exp_sat  = (eip > 32'sd1);
  assign exp_zero = (eip < -32'sd31);
  assign es       = 6'd2 - lval[37:32];
  assign rnd      = {1'b0, esum} + (35'd1 << (es - 6'd1));
  assign rsh      = rnd >> es;
  assign nat      = 34'((prod + (64'd1 << 29)) >> 30);

  assign res_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lldc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_stall  = 1'b1;
    rd_addr    = '0;
    mul_a      = '0;
    mul_b      = '0;
    mem_we     = 1'b0;
    case (state)
      lldc_pkg::S_IDLE: begin
        cmd_stall = 1'b0;
        rd_addr   = last_addr;
        if (cmd_valid) state_next = lldc_pkg::S_DISPATCH;
      end
      lldc_pkg::S_DISPATCH: begin
        case (op)
          lldc_pkg::CMD_APPEND: begin
            mem_we     = app_ok;
            state_next = lldc_pkg::S_DONE;
          end
          lldc_pkg::CMD_REMOVE: state_next = lldc_pkg::S_DONE;
          lldc_pkg::CMD_DISCOUNT: begin
            state_next = empty ? lldc_pkg::S_DONE : lldc_pkg::S_SRCH_RD;
          end
          default: begin
            state_next = (bad_iv || empty) ? lldc_pkg::S_DONE : lldc_pkg::S_SRCH_RD;
          end
        endcase
      end
      lldc_pkg::S_SRCH_RD: begin
        if (idx == count) begin
          rd_addr    = last_addr;
          state_next = lldc_pkg::S_NB_CAP;
        end else begin
          rd_addr    = idx[IW-1:0];
          state_next = lldc_pkg::S_SRCH_CMP;
        end
      end
      lldc_pkg::S_SRCH_CMP: begin
        rd_addr = IW'(idx - CW'(1));
        if (t_rd < qt) begin
          state_next = lldc_pkg::S_SRCH_RD;
        end else if (t_rd == qt) begin
          state_next = (op == lldc_pkg::CMD_DISCOUNT) ? lldc_pkg::S_DONE : lldc_pkg::S_LOG_LD;
        end else if (idx == '0) begin
          state_next = lldc_pkg::S_LOG_LD;
        end else begin
          state_next = lldc_pkg::S_NB_CAP;
        end
      end
      lldc_pkg::S_NB_CAP: begin
        if (kind == lldc_pkg::K_EXT && t_rd == '0) state_next = lldc_pkg::S_DONE;
        else state_next = lldc_pkg::S_LOG_LD;
      end
      lldc_pkg::S_LOG_LD: state_next = lldc_pkg::S_LOG_NORM;
      lldc_pkg::S_LOG_NORM: begin
        if (lm[31]) state_next = lldc_pkg::S_LOG_SQ;
      end
      lldc_pkg::S_LOG_SQ: begin
        mul_a      = lm;
        mul_b      = lm;
        state_next = lldc_pkg::S_LOG_ACC;
      end
      lldc_pkg::S_LOG_ACC: begin
        state_next = (lrc == 5'd31) ? lldc_pkg::S_LOG_DONE : lldc_pkg::S_LOG_SQ;
      end
      lldc_pkg::S_LOG_DONE: begin
        if (kind == lldc_pkg::K_EXACT) state_next = lldc_pkg::S_CURVE_DONE;
        else if (kind == lldc_pkg::K_INT && !second) state_next = lldc_pkg::S_LOG_LD;
        else state_next = lldc_pkg::S_MUL_LO;
      end
      lldc_pkg::S_MUL_LO: begin
        mul_a      = nmag[31:0];
        mul_b      = {8'b0, mt};
        state_next = lldc_pkg::S_MUL_HI;
      end
      lldc_pkg::S_MUL_HI: begin
        mul_a      = 32'(nmag[LW-1:32]);
        mul_b      = {8'b0, mt};
        state_next = lldc_pkg::S_MUL_ACC;
      end
      lldc_pkg::S_MUL_ACC: state_next = lldc_pkg::S_DIV;
      lldc_pkg::S_DIV: begin
        if (dcnt == 7'd1) begin
          case (duse)
            lldc_pkg::DU_CURVE: state_next = lldc_pkg::S_CURVE_FIX;
            lldc_pkg::DU_EXP:   state_next = lldc_pkg::S_EXP_TERM;
            default:            state_next = lldc_pkg::S_FWD_CHK;
          endcase
        end
      end
      lldc_pkg::S_CURVE_FIX: state_next = lldc_pkg::S_CURVE_DONE;
      lldc_pkg::S_CURVE_DONE: begin
        if (op == lldc_pkg::CMD_DISCOUNT) begin
          state_next = (exp_sat || exp_zero) ? lldc_pkg::S_DONE : lldc_pkg::S_EXP_Y;
        end else if (!pass) begin
          state_next = lldc_pkg::S_SRCH_RD;
        end else begin
          state_next = fbig ? lldc_pkg::S_DONE : lldc_pkg::S_DIV;
        end
      end
      lldc_pkg::S_EXP_Y: begin
        mul_a      = lval[31:0];
        mul_b      = lldc_pkg::LN2_Q32;
        state_next = lldc_pkg::S_EXP_YCAP;
      end
      lldc_pkg::S_EXP_YCAP: begin
        state_next = (prod[63:32] == '0) ? lldc_pkg::S_EXP_FIN : lldc_pkg::S_EXP_MUL;
      end
      lldc_pkg::S_EXP_MUL: begin
        if (ek > 5'(lldc_pkg::EXP_TERMS) || eterm == '0) begin
          state_next = lldc_pkg::S_EXP_FIN;
        end else begin
          mul_a      = eterm;
          mul_b      = ey;
          state_next = lldc_pkg::S_EXP_DIVLD;
        end
      end
      lldc_pkg::S_EXP_DIVLD: state_next = lldc_pkg::S_DIV;
      lldc_pkg::S_EXP_TERM:  state_next = lldc_pkg::S_EXP_MUL;
      lldc_pkg::S_EXP_FIN:   state_next = lldc_pkg::S_DONE;
      lldc_pkg::S_FWD_CHK: begin
        mul_a      = dquo[31:0];
        mul_b      = {2'b0, lldc_pkg::LN2_Q30};
        state_next = q_big ? lldc_pkg::S_DONE : lldc_pkg::S_FWD_FIN;
      end
      lldc_pkg::S_FWD_FIN: state_next = lldc_pkg::S_DONE;
      lldc_pkg::S_DONE: begin
        if (res_free) state_next = lldc_pkg::S_IDLE;
      end
      default: state_next = lldc_pkg::S_IDLE;
    endcase
  end

  // pillar store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tmem[count[IW-1:0]] <= ta;
      fmem[count[IW-1:0]] <= dfi;
    end
    t_rd <= tmem[rd_addr];
    f_rd <= fmem[rd_addr];
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == lldc_pkg::S_DISPATCH) begin
      if (op == lldc_pkg::CMD_APPEND && app_ok) begin
        count <= count + CW'(1);
      end else if (op == lldc_pkg::CMD_REMOVE && count > CW'(1)) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lldc_pkg::S_IDLE: begin
        if (cmd_valid) begin
          op  <= cmd_data.cmd;
          ta  <= cmd_data.time_a;
          tb  <= cmd_data.time_b;
          dfi <= cmd_data.discount_in;
        end
      end
      lldc_pkg::S_DISPATCH: begin
        r_status <= lldc_pkg::ST_OK;
        r_dout   <= '0;
        r_rout   <= '0;
        idx      <= '0;
        qt       <= ta;
        pass     <= 1'b0;
        case (op)
          lldc_pkg::CMD_APPEND: begin
            if (app_zero) r_status <= lldc_pkg::ST_ZERO_FACTOR;
            else if (app_noinc) r_status <= lldc_pkg::ST_NOT_INCREASING;
            else if (app_full) r_status <= lldc_pkg::ST_FULL;
          end
          lldc_pkg::CMD_REMOVE: begin
            if (count <= CW'(1)) r_status <= lldc_pkg::ST_LAST;
          end
          lldc_pkg::CMD_DISCOUNT: begin
            if (empty) r_status <= lldc_pkg::ST_EMPTY;
          end
          default: begin
            if (bad_iv) r_status <= lldc_pkg::ST_BAD_INTERVAL;
            else if (empty) r_status <= lldc_pkg::ST_EMPTY;
          end
        endcase
      end
      lldc_pkg::S_SRCH_RD: begin
        second <= 1'b0;
        if (idx == count) kind <= lldc_pkg::K_EXT;
      end
      lldc_pkg::S_SRCH_CMP: begin
        if (t_rd < qt) begin
          idx <= idx + CW'(1);
        end else if (t_rd == qt) begin
          kind <= lldc_pkg::K_EXACT;
          fa   <= f_rd;
          if (op == lldc_pkg::CMD_DISCOUNT) r_dout <= f_rd;
        end else begin
          hi_t <= t_rd;
          hi_f <= f_rd;
          if (idx == '0) begin
            kind <= lldc_pkg::K_EXT;
            fa   <= f_rd;
            mt   <= qt;
            dv   <= t_rd;
          end else begin
            kind <= lldc_pkg::K_INT;
          end
        end
      end
      lldc_pkg::S_NB_CAP: begin
        if (kind == lldc_pkg::K_EXT) begin
          if (t_rd == '0) r_status <= lldc_pkg::ST_ZERO_TIME;
          fa <= f_rd;
          mt <= qt;
          dv <= t_rd;
        end else begin
          fa <= hi_f;
          fb <= f_rd;
          mt <= qt - t_rd;
          dv <= hi_t - t_rd;
        end
      end
      lldc_pkg::S_LOG_LD: begin
        lm <= (fa == '0) ? 32'd1 : fa;
        lp <= 5'd31;
      end
      lldc_pkg::S_LOG_NORM: begin
        if (!lm[31]) begin
          lm <= {lm[30:0], 1'b0};
          lp <= lp - 5'd1;
        end else begin
          lrc   <= '0;
          lfrac <= '0;
        end
      end
      lldc_pkg::S_LOG_ACC: begin
        lfrac <= {lfrac[30:0], mm[32]};
        lm    <= mm[32] ? mm[32:1] : mm[31:0];
        lrc   <= lrc + 5'd1;
      end
      lldc_pkg::S_LOG_DONE: begin
        case (kind)
          lldc_pkg::K_EXACT: lval <= {{(64 - LW){lres[LW-1]}}, lres};
          lldc_pkg::K_EXT: begin
            base <= '0;
            nneg <= nsrc[LW-1];
            nmag <= nabs;
          end
          default: begin
            if (!second) begin
              lsave  <= lres;
              fa     <= fb;
              second <= 1'b1;
            end else begin
              base <= lres;
              nneg <= nsrc[LW-1];
              nmag <= nabs;
            end
          end
        endcase
      end
      lldc_pkg::S_MUL_HI: acc <= prod;
      lldc_pkg::S_MUL_ACC: begin
        dnum <= acc + {prod[31:0], 32'b0};
        dden <= dv;
        dcnt <= 7'd64;
        drem <= '0;
        dquo <= '0;
        duse <= lldc_pkg::DU_CURVE;
      end
      lldc_pkg::S_DIV: begin
        drem <= dge ? TW'(trial - {1'b0, dden}) : trial[TW-1:0];
        dquo <= {dquo[62:0], dge};
        dnum <= {dnum[62:0], 1'b0};
        dcnt <= dcnt - 7'd1;
      end
      lldc_pkg::S_CURVE_FIX: begin
        lval <= base_x + (nneg ? (~dquo + 64'd1) : dquo);
      end
      lldc_pkg::S_CURVE_DONE: begin
        if (op == lldc_pkg::CMD_DISCOUNT) begin
          if (exp_sat) r_dout <= '1;
        end else if (!pass) begin
          la   <= lval;
          pass <= 1'b1;
          qt   <= tb;
          idx  <= '0;
        end else begin
          nneg <= fd[63];
          if (fbig) r_rout <= fd[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          dnum <= {fmag[55:0], 8'b0};
          dden <= tb - ta;
          dcnt <= 7'd64;
          drem <= '0;
          dquo <= '0;
          duse <= lldc_pkg::DU_FWD;
        end
      end
      lldc_pkg::S_EXP_YCAP: begin
        ey    <= prod[63:32];
        eterm <= prod[63:32];
        esum  <= {2'b01, prod[63:32]};
        ek    <= 5'd2;
      end
      lldc_pkg::S_EXP_DIVLD: begin
        dnum <= {prod[63:32], 32'b0};
        dden <= TW'(ek);
        dcnt <= 7'd32;
        drem <= '0;
        dquo <= '0;
        duse <= lldc_pkg::DU_EXP;
      end
      lldc_pkg::S_EXP_TERM: begin
        eterm <= dquo[31:0];
        esum  <= esum + 34'(dquo[31:0]);
        ek    <= ek + 5'd1;
      end
      lldc_pkg::S_EXP_FIN: begin
        r_dout <= (|rsh[34:32]) ? 32'hFFFF_FFFF : rsh[31:0];
      end
      lldc_pkg::S_FWD_CHK: begin
        if (q_big) r_rout <= nneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      lldc_pkg::S_FWD_FIN: begin
        if (!nneg) begin
          r_rout <= (nat > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : nat[31:0];
        end else if (nat > 34'h0_8000_0000) begin
          r_rout <= 32'h8000_0000;
        end else begin
          r_rout <= ~nat[31:0] + 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == lldc_pkg::S_DONE && res_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lldc_pkg::S_DONE && res_free) begin
      res_data.status       <= r_status;
      res_data.discount_out <= r_dout;
      res_data.rate_out     <= $signed(r_rout);
    end
  end

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall) else $error("command taken while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(lldc_pkg::MAX_PILLARS)) else $error("pillar count overflow");

  a_count_only_dispatch: assert property (@(posedge clk) disable iff (rst)
    (state != lldc_pkg::S_DISPATCH) |=> (count == $past(count)))
    else $error("pillar count moved outside dispatch");

  a_log_normalized: assert property (@(posedge clk) disable iff (rst)
    (state == lldc_pkg::S_LOG_SQ) |-> lm[31]) else $error("log mantissa not normalized");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == lldc_pkg::S_DIV) |-> (drem < dden)) else $error("divider remainder too large");

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == lldc_pkg::S_DONE))
    else $error("result raised outside done");
`endif

endmodule

### sim/log_linear_discount_curve_top_tb.sv
module log_linear_discount_curve_top_tb;

  localparam longint ONE_Q32 = 64'sd4294967296;

  class curve_scoreboard;
    logic [lldc_pkg::TIME_W-1:0] times[lldc_pkg::MAX_PILLARS];
    logic [lldc_pkg::DF_W-1:0] factors[lldc_pkg::MAX_PILLARS];
    int count;
    lldc_pkg::res_item_t pending[$];
    int mismatches;
    int checked;

    function void clear();
      count = 0;
      mismatches = 0;
      checked = 0;
      pending.delete();
    endfunction

    function longint log2_fix(logic [31:0] df);
      int p;
      longint unsigned m;
      longint unsigned frac;
      p = 31;
      frac = 0;
      if (df == 0) df = 1;
      while (df[p] == 1'b0) p--;
      m = longint'(df) << (31 - p);
      for (int i = 0; i < 32; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      return longint'(p - 30) * ONE_Q32 + longint'(frac);
    endfunction

    function logic [31:0] exp2_fix(longint lg);
      longint unsigned f;
      longint ip;
      longint unsigned y;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned r;
      int s;
      f = lg & 64'hFFFF_FFFF;
      ip = (lg - longint'(f)) / ONE_Q32;
      if (ip >= 2) return 32'hFFFF_FFFF;
      if (ip < -31) return 32'd0;
      y = (f * 64'(lldc_pkg::LN2_Q32)) >> 32;
      term = 64'h1_0000_0000;
      sum = term;
      for (int k = 1; k <= lldc_pkg::EXP_TERMS && term != 0; k++) begin
        term = ((term * y) >> 32) / k;
        sum += term;
      end
      s = 2 - int'(ip);
      r = (sum + (64'd1 << (s - 1))) >> s;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      return r[31:0];
    endfunction

    function lldc_pkg::status_t curve_log(logic [lldc_pkg::TIME_W-1:0] t, output longint lg,
                                          output bit hit, output logic [31:0] df);
      int i;
      int e;
      longint l0;
      longint l1;
      i = 0;
      hit = 0;
      lg = 0;
      df = 0;
      if (count == 0) return lldc_pkg::ST_EMPTY;
      while (i < count && times[i] < t) i++;
      if (i < count && times[i] == t) begin
        hit = 1;
        df = factors[i];
        lg = log2_fix(factors[i]);
        return lldc_pkg::ST_OK;
      end
      if (i == 0 || i == count) begin
        e = (i == 0) ? 0 : count - 1;
        if (times[e] == 0) return lldc_pkg::ST_ZERO_TIME;
        lg = log2_fix(factors[e]) * longint'(t) / longint'(times[e]);
        return lldc_pkg::ST_OK;
      end
      l0 = log2_fix(factors[i-1]);
      l1 = log2_fix(factors[i]);
      lg = l0 + (l1 - l0) * (longint'(t) - longint'(times[i-1]))
           / (longint'(times[i]) - longint'(times[i-1]));
      return lldc_pkg::ST_OK;
    endfunction

    function void note_command(lldc_pkg::cmd_item_t c);
      lldc_pkg::res_item_t r;
      lldc_pkg::status_t st;
      longint la;
      longint lb;
      longint d;
      bit hit;
      logic [31:0] df;
      longint unsigned mag;
      longint unsigned q;
      longint unsigned nat;
      r = '0;
      st = lldc_pkg::ST_OK;
      case (lldc_pkg::cmd_t'(c.cmd))
        lldc_pkg::CMD_APPEND: begin
          if (c.discount_in == 0) st = lldc_pkg::ST_ZERO_FACTOR;
          else if (count > 0 && c.time_a <= times[count-1]) st = lldc_pkg::ST_NOT_INCREASING;
          else if (count >= lldc_pkg::MAX_PILLARS) st = lldc_pkg::ST_FULL;
          else begin
            times[count] = c.time_a;
            factors[count] = c.discount_in;
            count++;
          end
        end
        lldc_pkg::CMD_REMOVE: begin
          if (count <= 1) st = lldc_pkg::ST_LAST;
          else count--;
        end
        lldc_pkg::CMD_DISCOUNT: begin
          st = curve_log(c.time_a, la, hit, df);
          if (st == lldc_pkg::ST_OK) r.discount_out = hit ? df : exp2_fix(la);
        end
        default: begin
          if (c.time_b <= c.time_a) st = lldc_pkg::ST_BAD_INTERVAL;
          else begin
            st = curve_log(c.time_a, la, hit, df);
            if (st == lldc_pkg::ST_OK) st = curve_log(c.time_b, lb, hit, df);
          end
          if (st == lldc_pkg::ST_OK) begin
            d = la - lb;
            mag = (d < 0) ? longint'(0) - d : d;
            if (mag >= (64'd1 << 54)) q = 64'd1 << 32;
            else begin
              q = (mag << 8) / longint'(c.time_b - c.time_a);
              if (q > (64'd1 << 32)) q = 64'd1 << 32;
            end
            nat = (q * 64'(lldc_pkg::LN2_Q30) + (64'd1 << 29)) >> 30;
            if (d >= 0) r.rate_out = (nat > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : nat[31:0];
            else begin
              if (nat > 64'h8000_0000) nat = 64'h8000_0000;
              r.rate_out = 32'(64'd0 - nat);
            end
          end
        end
      endcase
      r.status = st;
      pending = {pending, r};
    endfunction

    function void check_result(lldc_pkg::res_item_t got);
      lldc_pkg::res_item_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.status !== exp_r.status || got.discount_out !== exp_r.discount_out ||
          got.rate_out !== exp_r.rate_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected st=%0d df=%h rate=%h, got st=%0d df=%h rate=%h",
                   exp_r.status, exp_r.discount_out, exp_r.rate_out,
                   got.status, got.discount_out, got.rate_out);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  lldc_pkg::cmd_item_t cmd_data;
  logic res_valid;
  logic res_stall;
  lldc_pkg::res_item_t res_data;

  curve_scoreboard board;
  longint cycles = 0;
  bit calm;
  int sent;

  log_linear_discount_curve_top u_dut (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .cmd_data(cmd_data), .res_valid(res_valid), .res_stall(res_stall),
    .res_data(res_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_command(lldc_pkg::cmd_t c, logic [23:0] ta, logic [23:0] tb,
                              logic [31:0] df);
    int gap;
    lldc_pkg::cmd_item_t item;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.cmd = c;
    item.time_a = ta;
    item.time_b = tb;
    item.discount_in = df;
    cmd_valid <= 1'b1;
    cmd_data <= item;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    board.note_command(item);
    sent++;
  endtask

  // receiver side, stalls drawn per result
  initial begin
    int wait_n;
    res_stall = 1'b1;
    @(negedge rst);
    forever begin
      wait_n = calm ? 0 : $urandom_range(0, 18);
      if (wait_n > 0) begin
        res_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      board.check_result(res_data);
    end
  end

  function automatic logic [31:0] pick_factor();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 255);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      2: return 32'h4000_0000 - $urandom_range(0, 32'h0400_0000);
      default: return $urandom_range(1, 32'h7FFF_FFFF) | ($urandom() & 32'h8000_0000);
    endcase
  endfunction

  task automatic build_curve(int n, bit from_zero);
    logic [23:0] t;
    t = from_zero ? 24'd0 : 24'($urandom_range(1, 24'h2_0000));
    for (int i = 0; i < n; i++) begin
      send_command(lldc_pkg::CMD_APPEND, t, 24'($urandom()), pick_factor());
      t = t + 24'($urandom_range(1, 24'h10_0000));
      if (t < 24'h10_0000 && i > 0) break;
    end
  endtask

  function automatic logic [23:0] near_time();
    int k;
    k = $urandom_range(0, board.count > 0 ? board.count - 1 : 0);
    if (board.count == 0) return 24'($urandom());
    case ($urandom_range(0, 3))
      0: return board.times[k];
      1: return board.times[k] + 24'($urandom_range(0, 24'h1_0000));
      2: return board.times[k] - 24'($urandom_range(0, 24'h1_0000));
      default: return 24'($urandom());
    endcase
  endfunction

  initial begin
    logic [23:0] a;
    logic [23:0] b;
    board = new();
    board.clear();
    sent = 0;
    calm = 0;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty curve, removals, bad intervals
    send_command(lldc_pkg::CMD_DISCOUNT, 24'h01_0000, 24'd0, 32'd0);
    send_command(lldc_pkg::CMD_FORWARD, 24'd0, 24'hFF_FFFF, 32'd0);
    send_command(lldc_pkg::CMD_FORWARD, 24'h10, 24'h10, 32'd0);
    send_command(lldc_pkg::CMD_REMOVE, 24'd0, 24'd0, 32'd0);
    send_command(lldc_pkg::CMD_APPEND, 24'd5, 24'd0, 32'd0);
    send_command(lldc_pkg::CMD_APPEND, 24'd0, 24'hFF_FFFF, 32'h2000_0000);
    send_command(lldc_pkg::CMD_REMOVE, 24'hFF_FFFF, 24'd0, 32'hFFFF_FFFF);
    send_command(lldc_pkg::CMD_DISCOUNT, 24'd0, 24'd0, 32'd0);
    send_command(lldc_pkg::CMD_DISCOUNT, 24'h02_0000, 24'd0, 32'd0);
    send_command(lldc_pkg::CMD_APPEND, 24'd0, 24'd0, 32'h1);
    send_command(lldc_pkg::CMD_APPEND, 24'h01_0000, 24'd0, 32'h3000_0000);
    send_command(lldc_pkg::CMD_APPEND, 24'hFF_FFFF, 24'd0, 32'hFFFF_FFFF);
    send_command(lldc_pkg::CMD_DISCOUNT, 24'h00_8000, 24'd0, 32'd0);
    send_command(lldc_pkg::CMD_DISCOUNT, 24'h80_0000, 24'd0, 32'd0);
    send_command(lldc_pkg::CMD_FORWARD, 24'h00_8000, 24'hFF_FFFF, 32'd0);
    send_command(lldc_pkg::CMD_FORWARD, 24'd0, 24'h00_0001, 32'd0);
    send_command(lldc_pkg::CMD_REMOVE, 24'd0, 24'd0, 32'd0);
    send_command(lldc_pkg::CMD_REMOVE, 24'd0, 24'd0, 32'd0);
    send_command(lldc_pkg::CMD_DISCOUNT, 24'h00_0100, 24'd0, 32'd0);
    send_command(lldc_pkg::CMD_REMOVE, 24'd0, 24'd0, 32'd0);
    // extrapolation from a last pillar at nonzero time, tiny and huge factors
    send_command(lldc_pkg::CMD_APPEND, 24'd1, 24'd0, 32'h8000_0000);
    send_command(lldc_pkg::CMD_DISCOUNT, 24'hFF_FFFF, 24'd0, 32'd0);
    send_command(lldc_pkg::CMD_APPEND, 24'd2, 24'd0, 32'd1);
    send_command(lldc_pkg::CMD_DISCOUNT, 24'hFF_FFFF, 24'd0, 32'd0);

    // random: rebuild curves of mixed size, then mixed commands
    while (sent < 420) begin
      while (board.count > 1)
        send_command(lldc_pkg::CMD_REMOVE, 24'($urandom()), 24'd0, 32'd0);
      send_command(lldc_pkg::CMD_APPEND, 24'($urandom()), 24'($urandom()), 32'd0);
      calm = ($urandom_range(0, 4) == 0);
      if (board.count == 1 && $urandom_range(0, 1)) begin
        send_command(lldc_pkg::CMD_REMOVE, 24'd0, 24'd0, 32'd0);
        build_curve(($urandom_range(0, 5) == 0) ? 18 : $urandom_range(1, 5),
                    $urandom_range(0, 3) == 0);
      end else begin
        build_curve($urandom_range(1, 4), 1'b0);
      end
      repeat ($urandom_range(4, 14)) begin
        a = near_time();
        b = near_time();
        case ($urandom_range(0, 9))
          0: send_command(lldc_pkg::CMD_APPEND, 24'($urandom()), 24'($urandom()), $urandom());
          1: send_command(lldc_pkg::CMD_REMOVE, 24'($urandom()), 24'($urandom()), $urandom());
          2, 3, 4, 5: send_command(lldc_pkg::CMD_DISCOUNT, a, 24'($urandom()), $urandom());
          default: begin
            if (a > b) send_command(lldc_pkg::CMD_FORWARD, b, a, $urandom());
            else send_command(lldc_pkg::CMD_FORWARD, a, b, $urandom());
          end
        endcase
      end
    end
    cmd_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    $display("sent %0d commands, checked %0d results", sent, board.checked);
    $display("covered empty, single and full curves, exact, interpolated and extrapolated");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
